/* rtl/core/fbpq_pkg.sv */
package fbpq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IN_W       = 32;
    // stored word: data_in is a 32-bit port, so never keep more than that
    localparam int WORD_W     = (DATA_WIDTH < IN_W) ? DATA_WIDTH : IN_W;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP        = 2'd2,
        CMD_FREEZE     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FROZEN = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // what the controller tells the row of cells this cycle
    typedef struct packed {
        logic             shift_back;   // push front: every word moves one place back
        logic             shift_front;  // pop: every word moves one place forward
        logic             load_back;    // push back: write at the fill position
        logic [CNT_W-1:0] fill;         // words held before this request
    } t_chain_op;

    typedef struct packed {
        logic shift_back;
        logic shift_front;
        logic load;
    } t_cell_op;

endpackage

/* rtl/core/fbpq_cell.sv */
module fbpq_cell
    import fbpq_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_op          i_op,
    input  logic [WORD_W-1:0] i_prev,
    input  logic [WORD_W-1:0] i_next,
    input  logic [WORD_W-1:0] i_data,
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_op.shift_back) begin
            n_word = i_prev;
        end else if (i_op.shift_front) begin
            n_word = i_next;
        end else if (i_op.load) begin
            n_word = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

/* rtl/core/fbpq_ctrl.sv */
module fbpq_ctrl
    import fbpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req,
    input  logic [1:0]        i_cmd,
    input  logic [WORD_W-1:0] i_front,
    output t_chain_op         o_op,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [IN_W-1:0]   o_data_out,
    output logic [4:0]        o_count,
    output logic              o_is_empty
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_frozen;
    logic             n_frozen;

    logic             r_done;
    t_status          r_status;
    t_status          n_status;
    logic [IN_W-1:0]  r_data;
    logic [IN_W-1:0]  n_data;
    logic [CNT_W-1:0] r_res_count;

    t_cmd             w_cmd;

    assign w_cmd = t_cmd'(i_cmd);

    always_comb begin
        n_count       = r_count;
        n_frozen      = r_frozen;
        n_status      = ST_OK;
        n_data        = '0;
        o_op          = '0;
        o_op.fill     = r_count;
        case (w_cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (r_frozen) begin
                    n_status = ST_FROZEN;
                end else if (r_count == CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    if (w_cmd == CMD_PUSH_BACK) begin
                        o_op.load_back = i_req;
                    end else begin
                        o_op.shift_back = i_req;
                    end
                end
            end
            CMD_POP: begin
                if (r_frozen) begin
                    n_status = ST_FROZEN;
                end else if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count          = r_count - 1'b1;
                    n_data           = IN_W'(i_front);
                    o_op.shift_front = i_req;
                end
            end
            default: begin
                // freeze: drop everything, refuse all later pushes and pops
                n_count  = '0;
                n_frozen = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_frozen <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_req;
            if (i_req) begin
                r_count  <= n_count;
                r_frozen <= n_frozen;
            end
        end
        if (i_req) begin
            r_status    <= n_status;
            r_data      <= n_data;
            r_res_count <= n_count;
        end
    end

    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_data_out = r_data;
    assign o_count    = 5'(r_res_count);
    assign o_is_empty = (r_res_count == '0);

endmodule

/* rtl/core/front_back_push_queue_top.sv */
// Bounded queue of up to DEPTH words that takes one request per clock: push at
// the back, push at the front, pop from the front, or freeze (drop all words
// and refuse every later push and pop until reset). busy stays low, so a
// request can be issued every cycle. Each request gives exactly one result,
// shown on the o_ ports in the cycle after the request, with o_done high;
// it cannot be held off and must be captured then. The words live in a row
// of cells that all move together: a front push shifts the row back, a pop
// shifts it forward, a back push writes the cell at the fill level. A pop on
// an empty, unfrozen queue returns zero with empty status; a push on a full
// queue is refused with full status.
module front_back_push_queue_top
    import fbpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_cmd,
    input  logic [IN_W-1:0]   i_data_in,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [IN_W-1:0]   o_data_out,
    output logic [4:0]        o_count,
    output logic              o_is_empty
);

    logic              w_req;
    t_chain_op         w_op;
    logic [WORD_W-1:0] w_data;
    logic [WORD_W-1:0] w_word [DEPTH];

    assign busy   = 1'b0;
    assign w_req  = start && !busy;
    assign w_data = WORD_W'(i_data_in);

    fbpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_cmd      (i_cmd),
        .i_front    (w_word[0]),
        .o_op       (w_op),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_data_out (o_data_out),
        .o_count    (o_count),
        .o_is_empty (o_is_empty)
    );

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_op          w_cell_op;
        logic [WORD_W-1:0] w_prev;
        logic [WORD_W-1:0] w_next;

        assign w_cell_op.shift_back  = w_op.shift_back;
        assign w_cell_op.shift_front = w_op.shift_front;
        assign w_cell_op.load        = w_op.load_back && (w_op.fill == CNT_W'(gi));

        if (gi == 0) begin : g_first
            assign w_prev = w_data;
        end else begin : g_mid
            assign w_prev = w_word[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_next = w_word[gi];
        end else begin : g_inner
            assign w_next = w_word[gi+1];
        end

        fbpq_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (w_cell_op),
            .i_prev (w_prev),
            .i_next (w_next),
            .i_data (w_data),
            .o_word (w_word[gi])
        );
    end

endmodule
